// ===== src/ivalu_pkg.sv =====
`default_nettype none

package ivalu_pkg;

    localparam int WIDTH = 32;

    // action(5) a_x a_y b_x b_y c_x c_y scalar
    localparam int OP_W      = 5;
    localparam int IN_BITS   = OP_W + 7 * WIDTH;
    localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA = ((2 * WIDTH + 7) / 8) * 8;

    // input register, operand stage, divider stages, lane result, output register
    localparam int LAT = WIDTH + 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 5'd0,
        OP_SUB      = 5'd1,
        OP_MUL      = 5'd2,
        OP_DIV      = 5'd3,
        OP_DIVFLOOR = 5'd4,
        OP_MODFLOOR = 5'd5,
        OP_MIN      = 5'd6,
        OP_MAX      = 5'd7,
        OP_NEG      = 5'd8,
        OP_ABS      = 5'd9,
        OP_SIGN     = 5'd10,
        OP_PERP     = 5'd11,
        OP_CROSS    = 5'd12,
        OP_CLAMP    = 5'd13,
        OP_SADD     = 5'd14,
        OP_SSUB     = 5'd15,
        OP_SMUL     = 5'd16,
        OP_SDIV     = 5'd17
    } t_op;

    typedef logic [WIDTH-1:0] t_word;

endpackage

`default_nettype wire

// ===== src/ivalu_lane.sv =====
`default_nettype none

module ivalu_lane (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  wire                 i_lane_y,
    input  ivalu_pkg::t_op      i_op,
    input  ivalu_pkg::t_word    i_a,
    input  ivalu_pkg::t_word    i_b,
    input  ivalu_pkg::t_word    i_b_alt,
    input  ivalu_pkg::t_word    i_c,
    input  ivalu_pkg::t_word    i_s,
    output ivalu_pkg::t_op      o_op,
    output ivalu_pkg::t_word    o_res
);
    import ivalu_pkg::*;

    localparam int W = WIDTH;

    // operand stage
    t_word             n_simple, n_prod, n_ua, n_ub, n_d, n_m;

    // divider pipeline, index 0 is the operand stage register
    t_word  r_rem    [0:W];
    t_word  r_quo    [0:W];
    t_word  r_ub     [0:W];
    t_word  r_simple [0:W];
    t_word  r_prod   [0:W];
    t_word  r_d      [0:W];
    logic   r_na     [0:W];
    logic   r_nd     [0:W];
    logic   r_dz     [0:W];
    t_op    r_op     [0:W];

    t_word  n_rem [0:W-1];
    t_word  n_quo [0:W-1];

    t_word  n_q, n_r, n_res;
    logic   n_adj;
    t_word  r_res;
    t_op    r_op_f;

    always_comb begin
        n_d = (i_op == OP_SDIV) ? i_s : i_b;
        if (i_op == OP_SMUL) begin
            n_m = i_s;
        end else if (i_op == OP_CROSS) begin
            n_m = i_b_alt;
        end else begin
            n_m = i_b;
        end
        // only the low word of the product is kept
        n_prod = i_a * n_m;
        n_ua   = i_a[W-1] ? (t_word'(0) - i_a) : i_a;
        n_ub   = n_d[W-1] ? (t_word'(0) - n_d) : n_d;

        case (i_op)
            OP_ADD:  n_simple = i_a + i_b;
            OP_SUB:  n_simple = i_a - i_b;
            OP_SADD: n_simple = i_a + i_s;
            OP_SSUB: n_simple = i_a - i_s;
            OP_MIN:  n_simple = ($signed(i_a) < $signed(i_b)) ? i_a : i_b;
            OP_MAX:  n_simple = ($signed(i_b) < $signed(i_a)) ? i_a : i_b;
            OP_NEG:  n_simple = t_word'(0) - i_a;
            OP_ABS:  n_simple = n_ua;
            OP_SIGN: begin
                if (i_a == '0) begin
                    n_simple = '0;
                end else if (i_a[W-1]) begin
                    n_simple = '1;
                end else begin
                    n_simple = t_word'(1);
                end
            end
            // the merge swaps lanes: x keeps a_x, y negates a_y
            OP_PERP: n_simple = i_lane_y ? (t_word'(0) - i_a) : i_a;
            OP_CLAMP: begin
                if ($signed(i_a) < $signed(i_b)) begin
                    n_simple = i_b;
                end else if ($signed(i_c) < $signed(i_a)) begin
                    n_simple = i_c;
                end else begin
                    n_simple = i_a;
                end
            end
            default: n_simple = '0;
        endcase
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        for (int k = 0; k < W; k++) begin
            logic [W:0] sh;
            logic [W:0] trial;
            sh       = {r_rem[k], r_quo[k][W-1]};
            trial    = sh - {1'b0, r_ub[k]};
            n_rem[k] = trial[W] ? sh[W-1:0] : trial[W-1:0];
            n_quo[k] = {r_quo[k][W-2:0], ~trial[W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]    <= '0;
            r_quo[0]    <= n_ua;
            r_ub[0]     <= n_ub;
            r_simple[0] <= n_simple;
            r_prod[0]   <= n_prod;
            r_d[0]      <= n_d;
            r_na[0]     <= i_a[W-1];
            r_nd[0]     <= n_d[W-1];
            r_dz[0]     <= (n_d == '0);
            r_op[0]     <= i_op;
            for (int k = 0; k < W; k++) begin
                r_rem[k+1]    <= n_rem[k];
                r_quo[k+1]    <= n_quo[k];
                r_ub[k+1]     <= r_ub[k];
                r_simple[k+1] <= r_simple[k];
                r_prod[k+1]   <= r_prod[k];
                r_d[k+1]      <= r_d[k];
                r_na[k+1]     <= r_na[k];
                r_nd[k+1]     <= r_nd[k];
                r_dz[k+1]     <= r_dz[k];
                r_op[k+1]     <= r_op[k];
            end
            r_res  <= n_res;
            r_op_f <= r_op[W];
        end
    end

    // sign fix, floor adjust and result select
    always_comb begin
        n_q   = (r_na[W] != r_nd[W]) ? (t_word'(0) - r_quo[W]) : r_quo[W];
        n_r   = r_na[W] ? (t_word'(0) - r_rem[W]) : r_rem[W];
        n_adj = (n_r != '0) && (r_na[W] != r_nd[W]);
        case (r_op[W])
            OP_MUL, OP_SMUL, OP_CROSS: n_res = r_prod[W];
            OP_DIV, OP_SDIV:           n_res = r_dz[W] ? '0 : n_q;
            OP_DIVFLOOR: n_res = r_dz[W] ? '0 : (n_adj ? n_q - t_word'(1) : n_q);
            OP_MODFLOOR: n_res = r_dz[W] ? '0 : (n_adj ? n_r + r_d[W] : n_r);
            default:                   n_res = r_simple[W];
        endcase
    end

    assign o_res = r_res;
    assign o_op  = r_op_f;

endmodule

`default_nettype wire

// ===== src/ivalu_merge.sv =====
`default_nettype none

module ivalu_merge (
    input  ivalu_pkg::t_op      i_op,
    input  ivalu_pkg::t_word    i_x,
    input  ivalu_pkg::t_word    i_y,
    output ivalu_pkg::t_word    o_x,
    output ivalu_pkg::t_word    o_y
);
    import ivalu_pkg::*;

    always_comb begin
        case (i_op)
            OP_CROSS: begin
                o_x = i_x - i_y;
                o_y = '0;
            end
            OP_PERP: begin
                o_x = i_y;
                o_y = i_x;
            end
            default: begin
                o_x = i_x;
                o_y = i_y;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/int_vector2_alu.sv =====
// channel   direction  tdata fields (lowest bit up)
// s_axis    in         action, a_x, a_y, b_x, b_y, c_x, c_y, scalar, zero pad
// m_axis    out        r_x, r_y
//
// Stages: input register, operand and multiply stage, one divider stage per
// quotient bit, lane result register, output register. Every lane runs a
// full pipelined divider. One transaction per cycle while not stalled.
// Synchronous active-low reset clears the valid bits only.
// A stalled output freezes the whole pipeline; bubbles are not collapsed.
`default_nettype none

module int_vector2_alu (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // action, a_x, a_y, b_x, b_y, c_x, c_y, scalar
    input  wire  [ivalu_pkg::IN_TDATA-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // r_x, r_y
    output logic [ivalu_pkg::OUT_TDATA-1:0]   o_m_axis_tdata
);
    import ivalu_pkg::*;

    localparam int W = WIDTH;

    logic          en;
    logic          r_v [0:LAT-1];
    t_op           r_op;
    t_word         r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_sc;
    t_op           op_x, op_y;
    t_word         res_x, res_y, mg_x, mg_y;
    t_word         r_out_x, r_out_y;
    t_op           r_out_op;

    assign en = !r_v[LAT-1] || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_s_axis_tvalid;
            for (int k = 1; k < LAT; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op     <= t_op'(i_s_axis_tdata[OP_W-1:0]);
            r_ax     <= i_s_axis_tdata[OP_W+0*W +: W];
            r_ay     <= i_s_axis_tdata[OP_W+1*W +: W];
            r_bx     <= i_s_axis_tdata[OP_W+2*W +: W];
            r_by     <= i_s_axis_tdata[OP_W+3*W +: W];
            r_cx     <= i_s_axis_tdata[OP_W+4*W +: W];
            r_cy     <= i_s_axis_tdata[OP_W+5*W +: W];
            r_sc     <= i_s_axis_tdata[OP_W+6*W +: W];
            r_out_x  <= mg_x;
            r_out_y  <= mg_y;
            r_out_op <= op_x;
        end
    end

    ivalu_lane u_lane_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_lane_y(1'b0),
        .i_op    (r_op),
        .i_a     (r_ax),
        .i_b     (r_bx),
        .i_b_alt (r_by),
        .i_c     (r_cx),
        .i_s     (r_sc),
        .o_op    (op_x),
        .o_res   (res_x)
    );

    ivalu_lane u_lane_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_lane_y(1'b1),
        .i_op    (r_op),
        .i_a     (r_ay),
        .i_b     (r_by),
        .i_b_alt (r_bx),
        .i_c     (r_cy),
        .i_s     (r_sc),
        .o_op    (op_y),
        .o_res   (res_y)
    );

    ivalu_merge u_merge (
        .i_op(op_x),
        .i_x (res_x),
        .i_y (res_y),
        .o_x (mg_x),
        .o_y (mg_y)
    );

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_v[LAT-1];
    assign o_m_axis_tdata  = {{(OUT_TDATA-2*W){1'b0}}, r_out_y, r_out_x};

`ifndef SYNTHESIS
    a_lane_op_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAT-2] |-> op_x == op_y)
        else $error("lane opcodes disagree");

    a_cross_y_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_out_op == OP_CROSS |-> r_out_y == '0)
        else $error("cross result y not zero");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a waiting result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
